// File: hdl/led_matrix_pwm_scanner_macros.svh
// Assertion macros shared by the checker of the LED matrix scanner.
// Each macro samples on the rising edge of clk and is disabled while rst is high.
`ifndef LED_MATRIX_PWM_SCANNER_MACROS_SVH
`define LED_MATRIX_PWM_SCANNER_MACROS_SVH

// The property holds at every clock edge outside reset.
`define LMPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// If the condition holds at one edge, the consequence holds at the next edge.
`define LMPS_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

// File: hdl/lmps_pkg.sv
package lmps_pkg;

  localparam int LEVELS      = 10;
  localparam int MAX_ROWS    = 16;
  localparam int MAX_COLUMNS = 8;

  // Internal widths that follow from the sizes above.
  localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int PIX_W    = $clog2(LEVELS + 1);
  localparam int WIDTH_W  = $clog2(MAX_COLUMNS + 1);
  localparam int HEIGHT_W = $clog2(MAX_ROWS + 1);

  // Port field widths.
  localparam int OP_W        = 2;
  localparam int FIELD_W     = 8;
  localparam int IN_DATA_W   = 3 * FIELD_W;
  localparam int PATTERN_W   = 8;
  localparam int ROW_NUM_W   = 4;
  localparam int LEVEL_OUT_W = 4;
  localparam int OUT_DATA_W  = PATTERN_W + ROW_NUM_W + LEVEL_OUT_W;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 5;
  localparam int AW_REG_W    = 4;
  localparam int AH_REG_W    = 5;

  // Command queue between the front and the back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Operation codes.
  localparam logic [OP_W-1:0] OP_SET_PIXEL = 2'd0;
  localparam logic [OP_W-1:0] OP_SCAN_TICK = 2'd1;
  localparam logic [OP_W-1:0] OP_RESTART   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HEIGHT = 1'b1;

  // One queued command: a pixel write, or a scan tick whose value is the threshold level.
  typedef struct packed {
    logic             is_tick;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] value;
    logic             last;
  } cmd_t;

endpackage

// File: hdl/lmps_front.sv
module lmps_front
  import lmps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [OP_W-1:0]       s_tuser,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  cmd_valid,
  output cmd_t                  cmd,
  input  logic                  cmd_ready,
  output logic [WIDTH_W-1:0]    eff_width
);

  logic [AW_REG_W-1:0] active_width;
  logic [AH_REG_W-1:0] active_height;
  logic [ROW_W-1:0]    scan_row;
  logic [PIX_W-1:0]    scan_level;

  logic [HEIGHT_W-1:0] eff_height;
  logic [ROW_W-1:0]    cur_row;
  logic [HEIGHT_W-1:0] row_inc;
  logic                row_wrap;
  logic                frame_last;
  logic [FIELD_W-1:0]  column;
  logic [FIELD_W-1:0]  row_select;
  logic [FIELD_W-1:0]  level_value;
  logic                set_ok;
  logic [PIX_W-1:0]    clamped;
  logic                accept;

  assign column      = s_tdata[FIELD_W-1:0];
  assign row_select  = s_tdata[2*FIELD_W-1:FIELD_W];
  assign level_value = s_tdata[3*FIELD_W-1:2*FIELD_W];

  assign s_tready = cmd_ready;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    if (active_width == '0) begin
      eff_width = WIDTH_W'(1);
    end else if (int'(active_width) > MAX_COLUMNS) begin
      eff_width = WIDTH_W'(MAX_COLUMNS);
    end else begin
      eff_width = WIDTH_W'(active_width);
    end
    if (active_height == '0) begin
      eff_height = HEIGHT_W'(1);
    end else if (int'(active_height) > MAX_ROWS) begin
      eff_height = HEIGHT_W'(MAX_ROWS);
    end else begin
      eff_height = HEIGHT_W'(active_height);
    end
  end

  // A lowered height can leave the scan beyond the last row; it then restarts at row zero.
  assign cur_row    = (HEIGHT_W'(scan_row) >= eff_height) ? '0 : scan_row;
  assign row_inc    = HEIGHT_W'(cur_row) + HEIGHT_W'(1);
  assign row_wrap   = row_inc >= eff_height;
  assign frame_last = (HEIGHT_W'(cur_row) == eff_height - HEIGHT_W'(1)) &&
                      (scan_level == PIX_W'(LEVELS));

  assign set_ok  = (int'(column) < int'(eff_width)) && (int'(row_select) < int'(eff_height));
  assign clamped = (int'(level_value) > LEVELS) ? PIX_W'(LEVELS) : level_value[PIX_W-1:0];

  always_comb begin
    cmd_valid = 1'b0;
    cmd       = '0;
    case (s_tuser)
      OP_SET_PIXEL: begin
        cmd_valid   = accept && set_ok;
        cmd.is_tick = 1'b0;
        cmd.row     = row_select[ROW_W-1:0];
        cmd.col     = column[COL_W-1:0];
        cmd.value   = clamped;
      end
      OP_SCAN_TICK: begin
        cmd_valid   = accept;
        cmd.is_tick = 1'b1;
        cmd.row     = cur_row;
        cmd.value   = scan_level;
        cmd.last    = frame_last;
      end
      default: begin
        cmd_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_width  <= AW_REG_W'(8);
      active_height <= AH_REG_W'(8);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ACTIVE_WIDTH:  active_width  <= cfg_data[AW_REG_W-1:0];
        REG_ACTIVE_HEIGHT: active_height <= cfg_data[AH_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_row   <= '0;
      scan_level <= PIX_W'(1);
    end else if (accept) begin
      case (s_tuser)
        OP_SCAN_TICK: begin
          if (row_wrap) begin
            scan_row   <= '0;
            scan_level <= (scan_level >= PIX_W'(LEVELS)) ? PIX_W'(1)
                                                          : scan_level + PIX_W'(1);
          end else begin
            scan_row <= row_inc[ROW_W-1:0];
          end
        end
        OP_RESTART: begin
          scan_row   <= '0;
          scan_level <= PIX_W'(1);
        end
        default: ;
      endcase
    end
  end

endmodule

// File: hdl/lmps_queue.sv
module lmps_queue
  import lmps_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  cmd_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t out_data
);

  cmd_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign in_ready  = count != QCNT_W'(QDEPTH);
  assign out_valid = count != '0;
  assign out_data  = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// File: hdl/lmps_back.sv
module lmps_back
  import lmps_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  input  cmd_t                   cmd,
  output logic                   cmd_ready,
  input  logic [WIDTH_W-1:0]     eff_width,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OUT_DATA_W-1:0]  out_data,
  output logic                   out_last
);

  logic [MAX_COLUMNS-1:0][PIX_W-1:0] frame_store [MAX_ROWS];
  logic [MAX_ROWS-1:0]               row_valid;

  logic [MAX_COLUMNS-1:0][PIX_W-1:0] rd_row;
  logic [MAX_COLUMNS-1:0][PIX_W-1:0] wr_row;
  logic [PATTERN_W-1:0]              pattern;
  logic                              out_free;
  logic                              take;

  logic [PATTERN_W-1:0]   out_pattern;
  logic [ROW_NUM_W-1:0]   out_row;
  logic [LEVEL_OUT_W-1:0] out_level;

  // A row never written since reset reads as dark.
  assign rd_row = row_valid[cmd.row] ? frame_store[cmd.row] : '0;

  always_comb begin
    wr_row          = rd_row;
    wr_row[cmd.col] = cmd.value;
  end

  always_comb begin
    pattern = '0;
    for (int j = 0; j < MAX_COLUMNS; j++) begin
      pattern[j] = (j < int'(eff_width)) && (rd_row[j] >= cmd.value);
    end
  end

  assign out_free  = !out_valid || out_ready;
  assign cmd_ready = !cmd.is_tick || out_free;
  assign take      = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (take && !cmd.is_tick) begin
      frame_store[cmd.row] <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (take && !cmd.is_tick) begin
      row_valid[cmd.row] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= cmd_valid && cmd.is_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (take && cmd.is_tick) begin
      out_pattern <= pattern;
      out_row     <= ROW_NUM_W'(cmd.row);
      out_level   <= LEVEL_OUT_W'(cmd.value);
      out_last    <= cmd.last;
    end
  end

  assign out_data = {out_level, out_row, out_pattern};

endmodule

// File: hdl/led_matrix_pwm_scanner.sv
// Multiplexed LED matrix scanner with brightness PWM.
// The input stream carries commands: tuser holds the operation (set pixel, scan tick or
// restart), tdata holds column, row and brightness. A set pixel stores a brightness,
// clamped to the top level, unless it falls outside the active width or height.
// Each scan tick yields one output transfer: the lit pattern of the current row at
// the current PWM threshold, with row number and threshold; tlast marks the last row
// of the last level, which closes a frame. Restart returns the scan to row 0, level 1.
// The plain write port sets the active width and height; write it only while idle.
// The front classifies commands and keeps the scan position, a four-entry queue
// follows, and the back holds the frame store and the output register.
// Path: with an empty queue and a free output register, an accepted tick passes through
// the queue and then the output register, in that order, before its result appears.
// Throughput: one command per cycle while the output is not stalled, limited by the single
// frame store row access made per cycle in the back.
// Reset clears every pixel to dark, puts the scan at row 0, level 1, and sets width
// and height to 8. When the receiver stalls, the pending result holds; further
// commands queue up to four deep, after which s_tready falls.
module led_matrix_pwm_scanner
  import lmps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // column [7:0], row_select [15:8], level_value [23:16]
  input  logic [OP_W-1:0]       s_tuser,   // operation [1:0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // row_pattern [7:0], row_number [11:8], pwm_level [15:12]
  output logic                  m_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic               push_valid;
  logic               push_ready;
  cmd_t               push_cmd;
  logic               pop_valid;
  logic               pop_ready;
  cmd_t               pop_cmd;
  logic [WIDTH_W-1:0] eff_width;

  // Front: accepts commands, applies bounds and clamping, steps the scan position.
  lmps_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (push_valid),
    .cmd       (push_cmd),
    .cmd_ready (push_ready),
    .eff_width (eff_width)
  );

  // Queue: keeps pixel writes and ticks in order so reads see earlier writes.
  lmps_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push_valid),
    .in_ready  (push_ready),
    .in_data   (push_cmd),
    .out_valid (pop_valid),
    .out_ready (pop_ready),
    .out_data  (pop_cmd)
  );

  // Back: frame store writes, row reads with threshold compares, output register.
  lmps_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (pop_valid),
    .cmd       (pop_cmd),
    .cmd_ready (pop_ready),
    .eff_width (eff_width),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

// File: hdl/lmps_checker.sv
`include "led_matrix_pwm_scanner_macros.svh"

module lmps_checker
  import lmps_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tlast
);

  logic [LEVEL_OUT_W-1:0] level;

  assign level = m_tdata[OUT_DATA_W-1:PATTERN_W+ROW_NUM_W];

  // A stalled result stays in place.
  `LMPS_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")

  // The threshold is always a real brightness level.
  `LMPS_ASSERT(a_level_range, !m_tvalid || (level != '0 && int'(level) <= LEVELS), "threshold out of range")

  // A frame ends only at the top level.
  `LMPS_ASSERT(a_frame_end_level, !m_tvalid || !m_tlast || int'(level) == LEVELS, "frame end below top level")

  // A result that follows a frame-end transfer, if valid, is at level 1.
  `LMPS_ASSERT_NEXT(a_after_frame, m_tvalid && m_tready && m_tlast, !m_tvalid || int'(level) == 1, "level did not wrap after frame end")

endmodule

bind led_matrix_pwm_scanner lmps_checker u_checker (.*);
